>>> src/zctpc_pkg.sv
// ----------------------------------------------------------------------------
// Zero-cross phase control package
// Shared types and constants for the zero-cross triac phase controller.
// ----------------------------------------------------------------------------
package zctpc_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_UNLOCKED = 2'd0,
    STATUS_REJECT   = 2'd1,
    STATUS_VALID    = 2'd2
  } status_e;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SMOKE_FAN_ON    = 3'd0;
  localparam logic [2:0] CFG_SMOKE_FAN_POWER = 3'd1;
  localparam logic [2:0] CFG_EXCHANGE_FAN_ON = 3'd2;
  localparam logic [2:0] CFG_FEED_ON         = 3'd3;
  localparam logic [2:0] CFG_FEED_MANUAL     = 3'd4;
  localparam logic [2:0] CFG_FEED_DUTY_PCT   = 3'd5;

  localparam logic [17:0] WRAP16       = 18'h0FFFF;
  localparam logic [17:0] WIN_LO       = 18'd19900;
  localparam logic [17:0] WIN_HI       = 18'd20100;
  localparam logic [15:0] DELAY_MIN    = 16'd10;
  localparam logic [15:0] DELAY_MAX    = 16'd800;
  localparam logic [9:0]  DELAY_FALLBACK = 10'd450;
  localparam logic [15:0] OFFSET_FLOOR = 16'd20;

  // floor(x / 10) == (x * RECIP10) >> RECIP10_SHIFT for every x below 2^19.
  localparam logic [18:0] RECIP10       = 19'd419431;
  localparam int          RECIP10_SHIFT = 22;

  // Five times the base firing delay for each power level.
  localparam logic [9:0] DELAY_X5 [0:5] = '{10'd575, 10'd550, 10'd525,
                                            10'd500, 10'd475, 10'd450};

  // Everything the phase math hands back to the top level.
  typedef struct packed {
    logic [17:0] first_mid;
    logic [17:0] second_mid;
    logic [15:0] period_sat;
    logic        lock_win;
    logic        run_win;
    logic [9:0]  delay;
  } phase_t;

  // Duty cycle write toward the feed sequencer.
  typedef struct packed {
    logic       duty_we;
    logic [6:0] duty;
  } feed_cfg_t;

endpackage

>>> src/zctpc_phase.sv
// ----------------------------------------------------------------------------
// Zero-cross phase math
// Pulse midpoints, mains period, window checks and smoke fan firing delay.
// ----------------------------------------------------------------------------
module zctpc_phase import zctpc_pkg::*; (
  input  logic [15:0] prev_fall_i,
  input  logic [15:0] prev_rise_i,
  input  logic [15:0] cur_fall_i,
  input  logic [15:0] cur_rise_i,
  input  logic [17:0] first_mid_i,
  input  logic [17:0] second_mid_i,
  input  logic [2:0]  power_i,
  output phase_t      phase_o
);

  logic [17:0] sum_prev, sum_cur;
  logic [17:0] half_prev, half_prev_wrap, half_cur, half_cur_wrap;
  logic [17:0] first_mid, second_mid;
  logic [18:0] diff;
  logic        neg;
  logic [18:0] off_sum, cur_rise_ext, off_raw;
  logic [37:0] prod;
  logic [15:0] quo, off_val, delay_sum;
  logic [2:0]  pw;

  assign sum_prev       = {2'b00, prev_fall_i} + {2'b00, prev_rise_i};
  assign sum_cur        = {2'b00, cur_fall_i} + {2'b00, cur_rise_i};
  assign half_prev      = sum_prev >> 1;
  assign half_prev_wrap = (sum_prev + WRAP16) >> 1;
  assign half_cur       = sum_cur >> 1;
  assign half_cur_wrap  = (sum_cur + WRAP16) >> 1;

  // Timer wrap cases; with no ordering case the old midpoints stay.
  always_comb begin
    first_mid  = first_mid_i;
    second_mid = second_mid_i;
    if (prev_fall_i < prev_rise_i && prev_rise_i < cur_fall_i && cur_fall_i < cur_rise_i) begin
      first_mid  = half_prev;
      second_mid = half_cur;
    end else if (prev_rise_i < prev_fall_i) begin
      first_mid  = half_prev_wrap;
      second_mid = half_cur + WRAP16;
    end else if (cur_fall_i < prev_rise_i) begin
      first_mid  = half_prev;
      second_mid = half_cur + WRAP16;
    end else if (cur_rise_i < cur_fall_i) begin
      first_mid  = half_prev;
      second_mid = half_cur_wrap;
    end
  end

  assign diff = {1'b0, second_mid} - {1'b0, first_mid};
  assign neg  = diff[18];

  // Offset to the next zero, in 10 microsecond units.
  assign off_sum      = {1'b0, second_mid} + {3'b000, diff[17:2]};
  assign cur_rise_ext = {3'b000, cur_rise_i};
  assign off_raw      = (off_sum > cur_rise_ext) ? (off_sum - cur_rise_ext)
                                                 : (off_sum + {1'b0, WRAP16} - cur_rise_ext);
  assign prod         = 38'(off_raw) * 38'(RECIP10);
  assign quo          = prod[RECIP10_SHIFT +: 16];
  assign off_val      = (quo == 16'd0) ? OFFSET_FLOOR : quo;

  always_comb begin
    if (power_i == 3'd0) begin
      pw = 3'd2;
    end else if (power_i > 3'd5) begin
      pw = 3'd5;
    end else begin
      pw = power_i;
    end
  end

  assign delay_sum = off_val + {6'd0, DELAY_X5[pw]};

  always_comb begin
    phase_o.first_mid  = first_mid;
    phase_o.second_mid = second_mid;
    if (neg || diff[17:16] != 2'b00) begin
      phase_o.period_sat = 16'hFFFF;
    end else begin
      phase_o.period_sat = diff[15:0];
    end
    phase_o.lock_win = !neg && diff[17:0] >= WIN_LO && diff[17:0] <= WIN_HI;
    phase_o.run_win  = !neg && diff[17:0] > WIN_LO && diff[17:0] < WIN_HI;
    if (delay_sum > DELAY_MAX || delay_sum < DELAY_MIN) begin
      phase_o.delay = DELAY_FALLBACK;
    end else begin
      phase_o.delay = delay_sum[9:0];
    end
  end

endmodule

>>> src/zctpc_feed.sv
// ----------------------------------------------------------------------------
// Feed burst sequencer
// Duty-cycled on/off half-cycle counter for the feed motor channel.
// ----------------------------------------------------------------------------
module zctpc_feed import zctpc_pkg::*; #(
  parameter int FEED_CYCLE = 500
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  feed_cfg_t cfg_i,
  input  logic      step_i,
  output logic      fire_o
);

  // On length for every duty code; codes above 100 act as 100.
  logic [8:0] on_tab [0:127];

  for (genvar g = 0; g < 128; g++) begin : g_on_tab
    localparam int OnLen = ((g > 100 ? 100 : g) * FEED_CYCLE) / 100;
    assign on_tab[g] = 9'(OnLen);
  end

  logic [8:0] on_len_q, off_len_q;
  logic [8:0] count_q, count_d, count_inc;
  logic       running_q, running_d;

  assign count_inc = count_q + 9'd1;

  always_comb begin
    count_d   = count_q;
    running_d = running_q;
    if (step_i) begin
      count_d = count_inc;
      if (running_q) begin
        if (count_inc >= on_len_q) begin
          count_d   = 9'd0;
          running_d = 1'b0;
        end
      end else if (count_inc >= off_len_q) begin
        count_d   = 9'd0;
        running_d = 1'b1;
      end
    end
  end

  assign fire_o = step_i && running_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_len_q  <= 9'd250;
      off_len_q <= 9'd250;
      count_q   <= 9'd0;
      running_q <= 1'b1;
    end else begin
      count_q   <= count_d;
      running_q <= running_d;
      if (cfg_i.duty_we && cfg_i.duty != 7'd0) begin
        on_len_q  <= on_tab[cfg_i.duty];
        off_len_q <= 9'(FEED_CYCLE) - on_tab[cfg_i.duty];
      end
    end
  end

endmodule

>>> src/zero_cross_triac_phase_control_top.sv
// ----------------------------------------------------------------------------
// Zero-cross triac phase control, top level
// Turns timestamped mains zero-cross edges into a per-half-cycle firing plan.
// ----------------------------------------------------------------------------
// The input stream carries one zero-cross edge per word: tuser says rising (1)
// or falling (0), tdata holds the 16-bit timer value. A falling edge is only
// recorded and yields no output word. Each rising edge yields one output word
// with status, smoke fan delay, the three channel fire flags and the period.
// A word waits in the input register, where the phase math and the
// feed sequencer run, and is then held in the output register: a rising edge
// moves on to the output register once that is free, and from there it can be
// taken by the receiver. One edge is taken every cycle unless a rising edge
// waits for a full output; the phase math is combinational.
// When the receiver stalls, the output register holds its word and the input
// register keeps the next edge; falling edges still drain past a full output.
// Reset clears the edge history, the lock and the channel enables, sets the
// smoke power to two, the feed on and off lengths to 250 half cycles each,
// and starts the feed sequencer in its on phase.
// Configuration writes take effect at the write edge.
// ----------------------------------------------------------------------------
module zero_cross_triac_phase_control_top import zctpc_pkg::*; #(
  parameter int LOCK_COUNT = 9,
  parameter int FEED_CYCLE = 500
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] edge_time
  input  logic        s_axis_tuser_i,   // [0] edge_rising
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [1:0] status, [11:2] fire_delay, [12] smoke_fire, [13] exchange_fire,
  // [14] feed_fire, [30:15] period_ticks, [31] zero
  output logic [31:0] m_axis_tdata_o
);

  // Input register.
  logic        s1_valid_q, s1_rising_q;
  logic [15:0] s1_time_q;

  // Edge history and lock.
  logic [15:0] prev_fall_q, prev_rise_q, cur_fall_q;
  logic [17:0] first_mid_q, second_mid_q;
  logic [3:0]  good_cnt_q, good_cnt_inc;
  logic        locked_q;

  // Configuration.
  logic        smoke_on_q, exchange_on_q, feed_on_q, feed_manual_q;
  logic [2:0]  power_q;

  // Output register.
  logic        m_valid_q;
  logic [31:0] m_data_q;

  logic        out_free, s1_move, rise_go, run_ok, feed_step, feed_fire;
  status_e     status;
  logic [9:0]  res_delay;
  logic        res_smoke, res_exchange, res_feed;
  phase_t      phase;
  feed_cfg_t   feed_cfg;

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s1_move         = s1_valid_q && (!s1_rising_q || out_free);
  assign s_axis_tready_o = !s1_valid_q || s1_move;
  assign rise_go         = s1_move && s1_rising_q;
  assign run_ok          = locked_q && phase.run_win;
  assign feed_step       = rise_go && run_ok && feed_on_q && !feed_manual_q;

  assign feed_cfg.duty_we = cfg_we_i && cfg_addr_i == CFG_FEED_DUTY_PCT;
  assign feed_cfg.duty    = cfg_wdata_i;

  zctpc_phase u_phase (
    .prev_fall_i  (prev_fall_q),
    .prev_rise_i  (prev_rise_q),
    .cur_fall_i   (cur_fall_q),
    .cur_rise_i   (s1_time_q),
    .first_mid_i  (first_mid_q),
    .second_mid_i (second_mid_q),
    .power_i      (power_q),
    .phase_o      (phase)
  );

  zctpc_feed #(
    .FEED_CYCLE (FEED_CYCLE)
  ) u_feed (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (feed_cfg),
    .step_i (feed_step),
    .fire_o (feed_fire)
  );

  assign good_cnt_inc = (good_cnt_q == 4'hF) ? 4'hF : good_cnt_q + 4'd1;

  always_comb begin
    status       = STATUS_UNLOCKED;
    res_delay    = 10'd0;
    res_smoke    = 1'b0;
    res_exchange = 1'b0;
    res_feed     = 1'b0;
    if (locked_q) begin
      if (phase.run_win) begin
        status       = STATUS_VALID;
        res_delay    = phase.delay;
        res_smoke    = smoke_on_q;
        res_exchange = exchange_on_q;
        res_feed     = feed_fire;
      end else begin
        status = STATUS_REJECT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      s1_rising_q   <= 1'b0;
      prev_fall_q   <= 16'd0;
      prev_rise_q   <= 16'd0;
      cur_fall_q    <= 16'd0;
      first_mid_q   <= 18'd0;
      second_mid_q  <= 18'd0;
      good_cnt_q    <= 4'd0;
      locked_q      <= 1'b0;
      smoke_on_q    <= 1'b0;
      power_q       <= 3'd2;
      exchange_on_q <= 1'b0;
      feed_on_q     <= 1'b0;
      feed_manual_q <= 1'b0;
      m_valid_q     <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        s1_valid_q  <= s_axis_tvalid_i;
        s1_rising_q <= s_axis_tuser_i;
      end

      if (s1_move && !s1_rising_q) begin
        cur_fall_q <= s1_time_q;
      end

      if (rise_go) begin
        first_mid_q  <= phase.first_mid;
        second_mid_q <= phase.second_mid;
        if (!locked_q) begin
          if (phase.lock_win) begin
            good_cnt_q <= good_cnt_inc;
            if (good_cnt_inc >= 4'(LOCK_COUNT)) begin
              locked_q <= 1'b1;
            end
          end else begin
            good_cnt_q <= 4'd0;
          end
        end
        // A rejected period leaves the edge history alone.
        if (!locked_q || phase.run_win) begin
          prev_fall_q <= cur_fall_q;
          prev_rise_q <= s1_time_q;
        end
      end

      if (rise_go) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_SMOKE_FAN_ON:    smoke_on_q    <= cfg_wdata_i[0];
          CFG_SMOKE_FAN_POWER: power_q       <= cfg_wdata_i[2:0];
          CFG_EXCHANGE_FAN_ON: exchange_on_q <= cfg_wdata_i[0];
          CFG_FEED_ON:         feed_on_q     <= cfg_wdata_i[0];
          CFG_FEED_MANUAL:     feed_manual_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o) begin
      s1_time_q <= s_axis_tdata_i;
    end
    if (rise_go) begin
      m_data_q <= {1'b0, phase.period_sat, res_feed, res_exchange, res_smoke,
                   res_delay, status};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // A firing plan always carries a delay inside the legal range.
  a_delay_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_data_q[1:0] == STATUS_VALID |->
      m_data_q[11:2] >= 10'd10 && m_data_q[11:2] <= 10'd800)
    else $error("firing delay out of range");

  // Without a firing plan no channel fires.
  a_no_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_data_q[1:0] != STATUS_VALID |->
      m_data_q[14:2] == 13'd0)
    else $error("channel fires without a valid plan");

  // Once locked, the block stays locked until reset.
  a_lock_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    locked_q |=> locked_q)
    else $error("lock dropped");

  // Only a rising edge loads a new output word.
  a_rise_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move && !s1_rising_q && m_valid_q && !m_axis_tready_i |=> m_valid_q && $stable(m_data_q))
    else $error("falling edge disturbed the output word");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Zero-cross triac phase control testbench
// Drives timestamped zero-cross edges into the block and predicts each firing
// plan word from its own model of the midpoint, lock, delay and feed logic.
// Output words are compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import zctpc_pkg::*;

  localparam bit EDGE_FALL = 1'b0;
  localparam bit EDGE_RISE = 1'b1;

  localparam int unsigned LOCK_RUN       = 9;
  localparam int unsigned FEED_CYCLE_LEN = 500;
  localparam int unsigned MAINS_LO       = 19900;
  localparam int unsigned MAINS_HI       = 20100;
  localparam int unsigned TICK_WRAP      = 'hFFFF;
  localparam int unsigned SLOW_FIRE      = 450;
  localparam int unsigned FIRE_MAX       = 800;
  localparam int unsigned FIRE_MIN       = 10;
  localparam int unsigned OFFSET_SUB     = 20;
  localparam int unsigned FIRE_BASE [6]  = '{115, 110, 105, 100, 95, 90};

  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 10;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PRINT_CAP     = 40;
  localparam int PHASES        = 8;
  localparam int RANDOM_ITEMS  = 1530;

  // Register settings per phase; the power walks through every code.
  localparam bit [7:0]   SMOKE_PLAN  = 8'b1010_1101;
  localparam bit [7:0]   EXCH_PLAN   = 8'b1011_0110;
  localparam bit [7:0]   FEED_PLAN   = 8'b1111_0111;
  localparam bit [7:0]   MANUAL_PLAN = 8'b0100_0100;
  localparam logic [6:0] DUTY_PLAN [8] = '{7'd2, 7'd98, 7'd0, 7'd100,
                                           7'd1, 7'd127, 7'd0, 7'd50};

  // Opening edges: wrap orderings, equal stamps, a period below the first
  // midpoint, back-to-back falling edges and a rising edge with no fall.
  localparam logic [16:0] OPENING [17] = '{
    {EDGE_RISE, 16'h0000},
    {EDGE_FALL, 16'hFFFF}, {EDGE_RISE, 16'h0000},
    {EDGE_FALL, 16'h0064}, {EDGE_RISE, 16'h0032},
    {EDGE_FALL, 16'hFFFF}, {EDGE_RISE, 16'hFFFE},
    {EDGE_FALL, 16'h0000}, {EDGE_RISE, 16'h0000},
    {EDGE_FALL, 16'h9C40}, {EDGE_FALL, 16'h7530}, {EDGE_RISE, 16'h7530},
    {EDGE_FALL, 16'hAFC8}, {EDGE_RISE, 16'h4E20},
    {EDGE_RISE, 16'hFFFF},
    {EDGE_FALL, 16'h5555}, {EDGE_RISE, 16'hAAAA}
  };

  // Same layout as m_axis_tdata_o[30:0].
  typedef struct packed {
    logic [15:0] period;
    logic        feed_fire;
    logic        exchange_fire;
    logic        smoke_fire;
    logic [9:0]  delay;
    status_e     status;
  } plan_t;

  class firing_plan_board;
    plan_t       plans_due[$];
    int unsigned faults;
    int unsigned words_seen;
    bit          smoke_on, exch_on, feed_on, feed_manual;
    bit [2:0]    power;
    bit [15:0]   fall_prev, rise_prev, fall_cur, rise_cur;
    int unsigned mid_a, mid_b, good_run;
    int unsigned feed_ctr, feed_on_len, feed_off_len;
    bit          locked, feed_running;

    function new();
      power        = 3'd2;
      feed_on_len  = FEED_CYCLE_LEN / 2;
      feed_off_len = FEED_CYCLE_LEN / 2;
      feed_running = 1'b1;
    endfunction

    function void write_reg(logic [2:0] idx, logic [6:0] val);
      int unsigned duty, on_ticks;
      case (idx)
        CFG_SMOKE_FAN_ON:    smoke_on = val[0];
        CFG_SMOKE_FAN_POWER: power = val[2:0];
        CFG_EXCHANGE_FAN_ON: exch_on = val[0];
        CFG_FEED_ON:         feed_on = val[0];
        CFG_FEED_MANUAL:     feed_manual = val[0];
        CFG_FEED_DUTY_PCT: begin
          // A zero duty leaves both lengths alone.
          if (val != 7'd0) begin
            duty = (val > 7'd100) ? 100 : val;
            on_ticks = duty * FEED_CYCLE_LEN / 100;
            feed_on_len  = on_ticks & 'h1FF;
            feed_off_len = (FEED_CYCLE_LEN - on_ticks) & 'h1FF;
          end
        end
        default: ;
      endcase
    endfunction

    function bit is_locked();
      return locked;
    endfunction

    function int unsigned pending();
      return plans_due.size();
    endfunction

    // Midpoint of the last pulse the block kept in its history.
    function int unsigned last_center();
      return fall_prev + ((rise_prev - fall_prev) & 16'hFFFF) / 2;
    endfunction

    function void note_edge(bit rising, bit [15:0] stamp);
      int unsigned t1, t3, t4, t6, period, offset, lvl, delay;
      plan_t p;
      if (rising == EDGE_FALL) begin
        fall_cur = stamp;
        return;
      end
      rise_cur = stamp;
      t1 = fall_prev;
      t3 = rise_prev;
      t4 = fall_cur;
      t6 = rise_cur;
      // When no ordering case matches, both midpoints keep their old values.
      if (t1 < t3 && t3 < t4 && t4 < t6) begin
        mid_a = (t1 + t3) / 2;
        mid_b = (t4 + t6) / 2;
      end else if (t3 < t1) begin
        mid_a = (t1 + t3 + TICK_WRAP) / 2;
        mid_b = (t4 + t6) / 2 + TICK_WRAP;
      end else if (t4 < t3) begin
        mid_a = (t1 + t3) / 2;
        mid_b = (t4 + t6) / 2 + TICK_WRAP;
      end else if (t6 < t4) begin
        mid_a = (t1 + t3) / 2;
        mid_b = (t4 + t6 + TICK_WRAP) / 2;
      end
      mid_a &= 'h3FFFF;
      mid_b &= 'h3FFFF;
      period = mid_b - mid_a;

      p = '0;
      p.status = STATUS_UNLOCKED;
      p.period = (period > 'hFFFF) ? 16'hFFFF : period[15:0];

      if (!locked) begin
        if (period >= MAINS_LO && period <= MAINS_HI) begin
          if (good_run < 15) good_run++;
          if (good_run >= LOCK_RUN) locked = 1'b1;
        end else begin
          good_run = 0;
        end
        fall_prev = t4;
        rise_prev = t6;
        plans_due.push_back(p);
        return;
      end

      // Once locked, the window is open at both ends and history is kept.
      if (period <= MAINS_LO || period >= MAINS_HI) begin
        p.status = STATUS_REJECT;
        plans_due.push_back(p);
        return;
      end
      fall_prev = t4;
      rise_prev = t6;

      offset = mid_b + period / 4;
      if (offset > t6) offset -= t6;
      else offset = offset + TICK_WRAP - t6;
      offset /= 10;
      if (offset == 0) offset = OFFSET_SUB;

      lvl = power;
      if (lvl == 0) lvl = 2;
      if (lvl > 5) lvl = 5;
      delay = (offset + 5 * FIRE_BASE[lvl]) & 'hFFFF;
      if (delay > FIRE_MAX || delay < FIRE_MIN) delay = SLOW_FIRE;

      if (feed_on && !feed_manual) begin
        feed_ctr = (feed_ctr + 1) & 'h1FF;
        if (feed_running) begin
          p.feed_fire = 1'b1;
          if (feed_ctr >= feed_on_len) begin
            feed_ctr = 0;
            feed_running = 1'b0;
          end
        end else if (feed_ctr >= feed_off_len) begin
          feed_ctr = 0;
          feed_running = 1'b1;
        end
      end

      p.status        = STATUS_VALID;
      p.delay         = delay[9:0];
      p.smoke_fire    = smoke_on;
      p.exchange_fire = exch_on;
      plans_due.push_back(p);
    endfunction

    task report(string what, logic [31:0] want, logic [31:0] got);
      faults++;
      if (faults <= PRINT_CAP)
        $display("MISMATCH word %0d %s: expected 0x%0h, got 0x%0h",
                 words_seen, what, want, got);
    endtask

    task check_plan(logic [31:0] word);
      plan_t want, got;
      words_seen++;
      if (plans_due.size() == 0) begin
        report("word with nothing expected", 32'd0, word);
        return;
      end
      want = plans_due.pop_front();
      got = plan_t'(word[30:0]);
      if (got.status !== want.status) report("status", want.status, got.status);
      if (got.delay !== want.delay) report("fire_delay", want.delay, got.delay);
      if (got.smoke_fire !== want.smoke_fire)
        report("smoke_fire", want.smoke_fire, got.smoke_fire);
      if (got.exchange_fire !== want.exchange_fire)
        report("exchange_fire", want.exchange_fire, got.exchange_fire);
      if (got.feed_fire !== want.feed_fire)
        report("feed_fire", want.feed_fire, got.feed_fire);
      if (got.period !== want.period) report("period_ticks", want.period, got.period);
      if (word[31] !== 1'b0) report("pad bit", 32'd0, word[31]);
    endtask

    task check_leftover();
      if (plans_due.size() != 0)
        report("words never received", 32'd0, plans_due.size());
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [6:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  firing_plan_board plans;
  int unsigned      items_sent;
  bit               tx_burst;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  zero_cross_triac_phase_control_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  task automatic send_edge(input bit rising, input bit [15:0] stamp);
    int unsigned gap;
    if ($urandom_range(0, 29) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 17);
    repeat (gap) begin
      @(negedge clk_i);
      s_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tuser  <= rising;
    s_tdata  <= stamp;
    do @(posedge clk_i); while (!s_tready);
    plans.note_edge(rising, stamp);
    items_sent++;
  endtask

  // One low pulse centered a period after the last pulse the block kept.
  task automatic send_pulse(input int unsigned period, input int unsigned width);
    int unsigned center;
    center = plans.last_center() + period;
    send_edge(EDGE_FALL, 16'(center - width / 2));
    send_edge(EDGE_RISE, 16'(center - width / 2 + width));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [6:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    plans.write_reg(idx, val);
  endtask

  task automatic write_settings(input int p);
    write_reg(CFG_SMOKE_FAN_ON, {6'd0, SMOKE_PLAN[p]});
    write_reg(CFG_SMOKE_FAN_POWER, 7'(p));
    write_reg(CFG_EXCHANGE_FAN_ON, {6'd0, EXCH_PLAN[p]});
    write_reg(CFG_FEED_ON, {6'd0, FEED_PLAN[p]});
    write_reg(CFG_FEED_MANUAL, {6'd0, MANUAL_PLAN[p]});
    write_reg(CFG_FEED_DUTY_PCT, DUTY_PLAN[p]);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Falling edges give no word, so settle keeps waiting after the last expected word to let them clear the block.
  task automatic settle();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (plans.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : receiver
    int unsigned hold;
    bit          rx_burst;
    hold = 0;
    rx_burst = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_tvalid && m_tready) begin
        plans.check_plan(m_tdata);
        if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
        hold = rx_burst ? 0 : $urandom_range(0, 17);
      end
      @(negedge clk_i);
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int unsigned r, period, width, quota;
    bit [15:0]   stamp;
    plans = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_settings(p);
      if (p == 0) begin
        for (int i = 0; i < 17; i++) send_edge(OPENING[i][16], OPENING[i][15:0]);
      end
      quota = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < quota) begin
        // Until the block locks, only clean mains pulses are sent.
        r = plans.is_locked() ? $urandom_range(0, 99) : 0;
        if (r < 75) begin
          period = $urandom_range(19920, 20080);
          case ($urandom_range(0, 19))
            0, 1:    width = period / 2 - $urandom_range(0, 25);
            2:       width = 0;
            default: width = $urandom_range(1, 10010);
          endcase
          send_pulse(period, width);
        end else if (r < 90) begin
          case ($urandom_range(0, 2))
            0:       period = $urandom_range(19895, 19905);
            1:       period = $urandom_range(20095, 20105);
            default: period = $urandom_range(0, 65535);
          endcase
          send_pulse(period, $urandom_range(0, 10010));
        end else begin
          stamp = 16'($urandom);
          case ($urandom_range(0, 2))
            0: send_edge(1'($urandom_range(0, 1)), stamp);
            1: begin
              send_edge(EDGE_FALL, stamp);
              send_edge(EDGE_RISE, stamp);
            end
            default: begin
              send_edge(EDGE_RISE, stamp);
              send_edge(EDGE_FALL, 16'($urandom));
            end
          endcase
        end
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    plans.check_leftover();
    if (plans.faults == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> files.f
src/zctpc_pkg.sv
src/zctpc_phase.sv
src/zctpc_feed.sv
src/zero_cross_triac_phase_control_top.sv
sim/testbench.sv
